// ===== hdl/tkps_pkg.sv =====
// ============================================================================
// Top-k plan selector package
// Shared widths, constants and word types of the top-k plan selector.
// ============================================================================
package tkps_pkg;

    localparam int KEEP_COUNT = 6;
    localparam int SPEED      = 30;
    localparam int ID_WIDTH   = 10;
    localparam int DIST_W     = 24;
    localparam int SCORE_W    = 24;
    localparam int TT_W       = 20;
    localparam int CFG_W      = 16;
    localparam int CNT_W      = $clog2(KEEP_COUNT + 1);

    localparam logic [CFG_W-1:0]  TIME_LIMIT_RESET = 16'hFFFF;
    localparam logic [DIST_W-1:0] LIMIT_PROD_RESET =
        DIST_W'(int'(TIME_LIMIT_RESET) * SPEED);

    // Travel time is distance times a rounded-up reciprocal of the speed.
    localparam int TT_SHIFT = DIST_W + $clog2(SPEED);
    localparam int RECIP_W  = DIST_W + 1;
    localparam int PROD_W   = DIST_W + RECIP_W;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << TT_SHIFT) + 64'(SPEED) - 64'd1) / 64'(SPEED);
    localparam logic [RECIP_W-1:0] TT_RECIP = RECIP_W'(RECIP_WIDE);

    typedef enum logic {
        FUNC_OFFER = 1'b0,
        FUNC_FLUSH = 1'b1
    } func_t;

    typedef struct packed {
        func_t                     func;
        logic [DIST_W-1:0]         trip_distance;
        logic signed [SCORE_W-1:0] plan_score;
        logic [ID_WIDTH-1:0]       activity_id;
        logic [ID_WIDTH-1:0]       dinner_id;
        logic [ID_WIDTH-1:0]       scenery_id;
    } in_word_t;

    typedef struct packed {
        logic                      found;
        logic signed [SCORE_W-1:0] best_score;
        logic [DIST_W-1:0]         best_distance;
        logic [TT_W-1:0]           travel_time;
        logic [ID_WIDTH-1:0]       out_activity;
        logic [ID_WIDTH-1:0]       out_dinner;
        logic [ID_WIDTH-1:0]       out_scenery;
        logic                      last;
    } out_word_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [DIST_W-1:0]         distance;
        logic [ID_WIDTH-1:0]       activity;
        logic [ID_WIDTH-1:0]       dinner;
        logic [ID_WIDTH-1:0]       scenery;
    } entry_t;

    typedef struct packed {
        logic   found;
        logic   last;
        entry_t entry;
    } res_req_t;

    typedef struct packed {
        logic             flushing;
        logic [CNT_W-1:0] count;
    } store_status_t;

endpackage

// ===== hdl/tkps_store.sv =====
// ============================================================================
// Top-k plan store
// Sorted register store of the best plans, with parallel insertion and a
// drain sequencer that shifts the kept plans out best first on a flush.
// ============================================================================
module tkps_store
    import tkps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  in_word_t          in_word,
    input  logic [DIST_W-1:0] limit_prod,
    output logic              take,
    output logic              res_valid,
    input  logic              res_ready,
    output res_req_t          res,
    output store_status_t     status
);

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    entry_t           ent_reg  [KEEP_COUNT];
    entry_t           ent_next [KEEP_COUNT];

    entry_t           new_ent;
    logic             full;
    logic [CNT_W-1:0] eff_count;
    logic             too_far;
    logic             weak_wins;
    logic [KEEP_COUNT-1:0] ge;

    assign new_ent.score    = in_word.plan_score;
    assign new_ent.distance = in_word.trip_distance;
    assign new_ent.activity = in_word.activity_id;
    assign new_ent.dinner   = in_word.dinner_id;
    assign new_ent.scenery  = in_word.scenery_id;

    assign full      = (count_reg == CNT_W'(KEEP_COUNT));
    assign eff_count = full ? CNT_W'(KEEP_COUNT - 1) : count_reg;
    assign too_far   = (in_word.trip_distance > limit_prod);
    assign weak_wins = full &&
        ($signed(ent_reg[KEEP_COUNT-1].score) > $signed(in_word.plan_score));

    // Kept plans that stay ahead of the new one form a prefix of the store.
    always_comb begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            ge[i] = (CNT_W'(i) < eff_count) &&
                    ($signed(ent_reg[i].score) >= $signed(in_word.plan_score));
        end
    end

    always_comb begin
        take        = 1'b0;
        res_valid   = 1'b0;
        res.found   = 1'b0;
        res.last    = 1'b1;
        res.entry   = '0;
        state_next  = state_reg;
        count_next  = count_reg;
        for (int i = 0; i < KEEP_COUNT; i++) begin
            ent_next[i] = ent_reg[i];
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_word.func == FUNC_OFFER) begin
                        take = 1'b1;
                        if (!too_far && !weak_wins) begin
                            if (!ge[0]) begin
                                ent_next[0] = new_ent;
                            end
                            for (int i = 1; i < KEEP_COUNT; i++) begin
                                if (!ge[i]) begin
                                    ent_next[i] = ge[i-1] ? new_ent : ent_reg[i-1];
                                end
                            end
                            count_next = eff_count + CNT_W'(1);
                        end
                    end else if (count_reg != '0) begin
                        take       = 1'b1;
                        state_next = ST_FLUSH;
                    end else if (res_ready) begin
                        take      = 1'b1;
                        res_valid = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                res_valid = 1'b1;
                res.found = 1'b1;
                res.last  = (count_reg == CNT_W'(1));
                res.entry = ent_reg[0];
                if (res_ready) begin
                    for (int i = 0; i < KEEP_COUNT - 1; i++) begin
                        ent_next[i] = ent_reg[i+1];
                    end
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    assign status.flushing = (state_reg == ST_FLUSH);
    assign status.count    = count_reg;

endmodule

// ===== hdl/tkps_result.sv =====
// ============================================================================
// Top-k plan result stage
// Works out the travel time of an emitted plan and holds the result word in
// the output register until the receiver takes it.
// ============================================================================
module tkps_result
    import tkps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      res_valid,
    output logic      res_ready,
    input  res_req_t  res,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic              m_valid_reg;
    out_word_t         m_data_reg;
    logic [PROD_W-1:0] prod;
    logic [TT_W-1:0]   travel_time;

    assign prod        = PROD_W'(res.entry.distance) * PROD_W'(TT_RECIP);
    assign travel_time = TT_W'(prod >> TT_SHIFT);
    assign res_ready   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg.found         <= res.found;
            m_data_reg.best_score    <= res.entry.score;
            m_data_reg.best_distance <= res.entry.distance;
            m_data_reg.travel_time   <= travel_time;
            m_data_reg.out_activity  <= res.entry.activity;
            m_data_reg.out_dinner    <= res.entry.dinner;
            m_data_reg.out_scenery   <= res.entry.scenery;
            m_data_reg.last          <= res.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/top_k_plan_selector.sv =====
// ============================================================================
// Top-k plan selector
// Keeps the six best plans by score that meet the travel time limit and
// emits them best first on a flush.
// ============================================================================
// Usage: the s_ channel carries one word per candidate plan or flush command;
// the m_ channel returns result words; cfg_ writes the time limit, and is
// always ready. The limit takes effect on the following cycle.
// An offered plan passes through the input register and is then filtered and
// inserted into the sorted store, so offers are taken one per cycle while the
// store is not draining, and produce no result.
// A flush with plans kept moves from the input register into the drain
// sequence, and the store shifts one plan a cycle into the output register
// while that register can take it; the store takes no input until the drain
// ends. A flush of an empty store yields one empty word.
// When the receiver stalls, the output register holds its word, the drain
// pauses, and the input register holds one more word before s_ready drops.
// Reset empties the store, clears both valid flags and sets the time limit
// to its greatest value.
// ============================================================================
module top_k_plan_selector
    import tkps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic              in_valid_reg;
    in_word_t          in_word_reg;
    logic [DIST_W-1:0] limit_prod_reg;
    logic              store_take;
    logic              res_valid;
    logic              res_ready;
    res_req_t          res;
    store_status_t     st;

    assign cfg_ready = 1'b1;
    assign s_ready   = !in_valid_reg || store_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_prod_reg <= LIMIT_PROD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_prod_reg <= DIST_W'(int'(cfg_data) * SPEED);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
    end

    tkps_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_word    (in_word_reg),
        .limit_prod (limit_prod_reg),
        .take       (store_take),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .status     (st)
    );

    tkps_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTH
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> m_data.last)
        else $error("empty result word without last");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st.count <= CNT_W'(KEEP_COUNT))
        else $error("kept plan count above store depth");

    a_no_take_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        st.flushing |-> !store_take)
        else $error("input word taken during drain");

    a_drain_ends_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (st.flushing && st.count == CNT_W'(1) && res_ready) |=> (m_valid && m_data.last))
        else $error("drain finished without last word");
`endif

endmodule

// ===== bench/tkps_checker.sv =====
// ============================================================================
// Top-k plan selector checker
// Watches the input, result and limit channels of the selector, keeps its
// own sorted store of the best plans, and compares every result word with
// the oldest predicted word, counting mismatches for the bench top.
// ============================================================================
`timescale 1ns / 100ps

module tkps_checker
    import tkps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_word_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_word_t        m_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int REPORT_LIMIT = 10;

    logic [CFG_W-1:0] limit_now;
    entry_t           kept_plans [KEEP_COUNT];
    int               kept_n;
    out_word_t        due_words [$];

    task automatic offer_plan(input in_word_t w);
        logic signed [SCORE_W-1:0] s_new;
        logic signed [SCORE_W-1:0] weakest;
        int unsigned               cap;
        int                        pos;
        int                        i;
        begin
            s_new = w.plan_score;
            cap   = SPEED * int'(limit_now);
            if (int'(w.trip_distance) > cap) return;
            if (kept_n >= KEEP_COUNT) begin
                weakest = kept_plans[KEEP_COUNT-1].score;
                if (weakest > s_new) return;
                kept_n = KEEP_COUNT - 1;
            end
            pos = 0;
            while (pos < kept_n && $signed(kept_plans[pos].score) >= s_new) pos++;
            for (i = kept_n; i > pos; i--) kept_plans[i] = kept_plans[i-1];
            kept_plans[pos].score    = s_new;
            kept_plans[pos].distance = w.trip_distance;
            kept_plans[pos].activity = w.activity_id;
            kept_plans[pos].dinner   = w.dinner_id;
            kept_plans[pos].scenery  = w.scenery_id;
            kept_n++;
        end
    endtask

    task automatic flush_plans();
        out_word_t   w;
        int unsigned plan_dist;
        int          k;
        begin
            if (kept_n == 0) begin
                w      = '0;
                w.last = 1'b1;
                due_words.insert(due_words.size(), w);
            end else begin
                for (k = 0; k < kept_n; k++) begin
                    plan_dist       = kept_plans[k].distance;
                    w.found         = 1'b1;
                    w.best_score    = kept_plans[k].score;
                    w.best_distance = kept_plans[k].distance;
                    w.travel_time   = TT_W'(plan_dist / SPEED);
                    w.out_activity  = kept_plans[k].activity;
                    w.out_dinner    = kept_plans[k].dinner;
                    w.out_scenery   = kept_plans[k].scenery;
                    w.last          = (k + 1 == kept_n);
                    due_words.insert(due_words.size(), w);
                end
            end
            kept_n = 0;
        end
    endtask

    task automatic check_word(input out_word_t got);
        out_word_t want;
        logic      bad;
        begin
            if (due_words.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result word %h", got);
            end else begin
                want = due_words.pop_front();
                bad  = (got.found !== want.found) ||
                       (got.best_score !== want.best_score) ||
                       (got.best_distance !== want.best_distance) ||
                       (got.travel_time !== want.travel_time) ||
                       (got.out_activity !== want.out_activity) ||
                       (got.out_dinner !== want.out_dinner) ||
                       (got.out_scenery !== want.out_scenery) ||
                       (got.last !== want.last);
                if (bad) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("expected f=%0d s=%0d d=%0d t=%0d ids=%0d/%0d/%0d l=%0d",
                                 want.found, want.best_score, want.best_distance,
                                 want.travel_time, want.out_activity, want.out_dinner,
                                 want.out_scenery, want.last);
                        $display("actual   f=%0d s=%0d d=%0d t=%0d ids=%0d/%0d/%0d l=%0d",
                                 got.found, got.best_score, got.best_distance,
                                 got.travel_time, got.out_activity, got.out_dinner,
                                 got.out_scenery, got.last);
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            limit_now  = TIME_LIMIT_RESET;
            kept_n     = 0;
            fail_count = 0;
            due_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) limit_now = cfg_data;
            if (m_valid && m_ready) check_word(m_data);
            if (s_valid && s_ready) begin
                if (s_data.func == FUNC_FLUSH) flush_plans();
                else offer_plan(s_data);
            end
        end
        pending = due_words.size();
    end

endmodule

// ===== bench/top_k_plan_selector_tb.sv =====
// ============================================================================
// Top-k plan selector testbench
// Drives candidate plans, flushes and time limit writes into the selector
// under random stalls on both sides; a checker beside the block predicts
// every result word and counts mismatches for the final verdict.
// ============================================================================
`timescale 1ns / 100ps

module top_k_plan_selector_tb;
    import tkps_pkg::*;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_word_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_word_t        m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               send_idle_pct;
    int               recv_idle_pct;

    top_k_plan_selector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tkps_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic in_word_t plan_word(input logic [DIST_W-1:0] dist_in,
                                           input logic [SCORE_W-1:0] score);
        in_word_t w;
        begin
            w.func          = FUNC_OFFER;
            w.trip_distance = dist_in;
            w.plan_score    = score;
            w.activity_id   = ID_WIDTH'($urandom);
            w.dinner_id     = ID_WIDTH'($urandom);
            w.scenery_id    = ID_WIDTH'($urandom);
            return w;
        end
    endfunction

    function automatic in_word_t flush_word();
        in_word_t w;
        begin
            w      = plan_word(DIST_W'($urandom), SCORE_W'($urandom));
            w.func = FUNC_FLUSH;
            return w;
        end
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance(input logic [CFG_W-1:0] lim);
        int unsigned cap;
        int unsigned r;
        begin
            cap = SPEED * int'(lim);
            r   = $urandom_range(0, 9);
            if (r < 2) return DIST_W'($urandom);
            if (r < 4) return DIST_W'(cap + $urandom_range(0, 1));
            return DIST_W'($urandom_range(0, cap));
        end
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score();
        int unsigned r;
        begin
            r = $urandom_range(0, 9);
            if (r < 3) return SCORE_W'($urandom);
            if (r < 6) return SCORE_W'(int'($urandom_range(0, 6)) - 3);
            if (r == 6) return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            return SCORE_W'(int'($urandom_range(0, 2000)) - 1000);
        end
    endfunction

    task automatic drive_word(input in_word_t w);
        begin
            @(negedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= w;
            do begin
                @(posedge aclk);
            end while (!s_ready);
        end
    endtask

    // The block may still be filtering an offer when the last result leaves.
    task automatic wait_drained();
        begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (2) @(posedge aclk);
            while (pending != 0) @(posedge aclk);
            repeat (8) @(posedge aclk);
        end
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            do begin
                @(posedge aclk);
            end while (!cfg_ready);
            @(negedge aclk);
            cfg_valid <= 1'b0;
        end
    endtask

    initial begin
        #2_000_000;
        $display("[top_k_plan_selector] ERROR");
        $finish;
    end

    initial begin
        int               seg;
        int               sent;
        int               burst;
        int               k;
        logic [CFG_W-1:0] lim;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        send_idle_pct = 14;
        recv_idle_pct = 74;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset limit, then at the two smallest limits.
        drive_word(flush_word());
        drive_word(plan_word(24'd0, 24'h7FFFFF));
        drive_word(plan_word(24'd1966050, 24'h800000));
        drive_word(plan_word(24'd1966051, 24'd5));
        drive_word(plan_word(24'hFFFFFF, 24'd7));
        drive_word(flush_word());
        for (k = 1; k <= 6; k++) drive_word(plan_word(DIST_W'(k * 100), SCORE_W'(k * 10)));
        drive_word(plan_word(24'd77, 24'd10));
        drive_word(plan_word(24'd78, 24'd9));
        drive_word(plan_word(24'd79, 24'd20));
        drive_word(flush_word());
        drive_word(flush_word());
        wait_drained();
        write_limit(16'd0);
        drive_word(plan_word(24'd0, 24'hFFFFFF));
        drive_word(plan_word(24'd1, 24'd3));
        drive_word(flush_word());
        wait_drained();
        write_limit(16'd1);
        drive_word(plan_word(24'd30, 24'd1));
        drive_word(plan_word(24'd31, 24'd2));
        drive_word(flush_word());

        for (seg = 0; seg < 11; seg++) begin
            wait_drained();
            if (seg < 4) begin
                send_idle_pct = 14;
                recv_idle_pct = 74;
            end else if (seg < 8) begin
                send_idle_pct = 74;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg % 5)
                0: lim = CFG_W'($urandom_range(0, 65535));
                1: lim = 16'hFFFF;
                2: lim = 16'd0;
                3: lim = CFG_W'($urandom_range(1, 200));
                default: lim = CFG_W'($urandom_range(60000, 65534));
            endcase
            write_limit(lim);
            sent = 0;
            while (sent < 25) begin
                burst = $urandom_range(0, 10);
                for (k = 0; k < burst; k++)
                    drive_word(plan_word(pick_distance(lim), pick_score()));
                sent += burst;
                if ($urandom_range(0, 99) < 85) begin
                    drive_word(flush_word());
                    sent++;
                end
            end
            drive_word(flush_word());
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("[top_k_plan_selector] OK");
        end else begin
            $display("[top_k_plan_selector] ERROR");
        end
        $finish;
    end

endmodule
